/* rtl/assert_macros.svh */
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/ubx_pkg.sv */
// Types and constants of the UBX frame receiver
package ubx_pkg;

    localparam logic [7:0] SYNC_FIRST      = 8'hB5;
    localparam logic [7:0] SYNC_SECOND     = 8'h62;
    localparam logic [8:0] PAYLOAD_CEILING = 9'd256;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
    localparam logic [1:0] STATUS_LENGTH  = 2'd2;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic [1:0]  frame_status;
        logic        last_of_frame;
    } result_t;

endpackage

/* rtl/ubx_parse.sv */
// Frame parser: sync hunt, header capture, Fletcher sums, result decode
module ubx_parse
    import ubx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    output logic        res_valid,
    output result_t     res
);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  class_reg, class_next;
    logic [7:0]  id_reg, id_next;
    logic [15:0] length_reg, length_next;
    logic [8:0]  count_reg, count_next;
    logic [7:0]  check_a_reg, check_a_next;
    logic [8:0]  max_len_reg;

    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] len_full;
    logic [8:0]  limit;
    logic [8:0]  count_inc;

    assign add_a     = sum_a_reg + rx_byte;
    assign add_b     = sum_b_reg + add_a;
    assign len_full  = {rx_byte, length_reg[7:0]};
    assign limit     = (max_len_reg > PAYLOAD_CEILING) ? PAYLOAD_CEILING : max_len_reg;
    assign count_inc = count_reg + 9'd1;

    always_comb begin
        phase_next   = phase_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        class_next   = class_reg;
        id_next      = id_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        check_a_next = check_a_reg;
        res_valid    = 1'b0;
        res.item_kind     = KIND_PAYLOAD;
        res.payload_byte  = 8'd0;
        res.byte_index    = 8'd0;
        res.frame_class   = class_reg;
        res.frame_id      = id_reg;
        res.frame_length  = length_reg;
        res.frame_status  = STATUS_OK;
        res.last_of_frame = 1'b0;
        unique case (phase_reg)
            PH_SYNC2: begin
                if (rx_byte == SYNC_SECOND) begin
                    sum_a_next = 8'd0;
                    sum_b_next = 8'd0;
                    phase_next = PH_CLASS;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_CLASS: begin
                class_next = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = PH_ID;
            end
            PH_ID: begin
                id_next    = rx_byte;
                sum_a_next = add_a;
                sum_b_next = add_b;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next = {8'd0, rx_byte};
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next = len_full;
                sum_a_next  = add_a;
                sum_b_next  = add_b;
                count_next  = 9'd0;
                if (len_full > {7'd0, limit}) begin
                    res_valid         = 1'b1;
                    res.item_kind     = KIND_END;
                    res.frame_length  = len_full;
                    res.frame_status  = STATUS_LENGTH;
                    res.last_of_frame = 1'b1;
                    phase_next        = PH_HUNT;
                end else if (len_full == 16'd0) begin
                    phase_next = PH_CK_A;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                sum_a_next       = add_a;
                sum_b_next       = add_b;
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                res.byte_index   = count_reg[7:0];
                count_next       = count_inc;
                if ({7'd0, count_inc} >= length_reg) begin
                    phase_next = PH_CK_A;
                end
            end
            PH_CK_A: begin
                check_a_next = rx_byte;
                phase_next   = PH_CK_B;
            end
            PH_CK_B: begin
                res_valid         = 1'b1;
                res.item_kind     = KIND_END;
                res.last_of_frame = 1'b1;
                res.frame_status  = (check_a_reg == sum_a_reg && rx_byte == sum_b_reg)
                                    ? STATUS_OK : STATUS_CHECKSUM;
                phase_next        = PH_HUNT;
            end
            default: begin
                phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            sum_a_reg   <= 8'd0;
            sum_b_reg   <= 8'd0;
            class_reg   <= 8'd0;
            id_reg      <= 8'd0;
            length_reg  <= 16'd0;
            count_reg   <= 9'd0;
            check_a_reg <= 8'd0;
            max_len_reg <= PAYLOAD_CEILING;
        end else begin
            if (step) begin
                phase_reg   <= phase_next;
                sum_a_reg   <= sum_a_next;
                sum_b_reg   <= sum_b_next;
                class_reg   <= class_next;
                id_reg      <= id_next;
                length_reg  <= length_next;
                count_reg   <= count_next;
                check_a_reg <= check_a_next;
            end
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

endmodule

/* rtl/ubx_out_buf.sv */
// Two-entry result buffer: output register plus skid register
module ubx_out_buf
    import ubx_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

`include "assert_macros.svh"

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    take;

    assign take      = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    `ASSERT_IMPLIES(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPLIES(a_no_push_when_full, aclk, aresetn, skid_valid_reg, !push)
    `ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn, push && out_valid_reg && !out_ready, skid_valid_reg)
    `ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && out_ready, out_valid_reg && !skid_valid_reg)

endmodule

/* rtl/ubx_frame_receiver_top.sv */
// Top level of the UBX frame receiver
//
//  channel  | signals                  | beat
//  ---------+--------------------------+---------------------------------
//  input    | s_valid/s_ready/s_rx_byte| one received byte
//  result   | m_valid/m_ready/m_*      | payload byte or frame end
//  config   | cfg_wr_en/cfg_wr_data    | max payload length, no handshake
//
// One byte per cycle while s_ready is high; each result is registered in the output buffer.
// Parser state advances once per accepted byte; a two-entry output buffer
// keeps s_ready high until both entries are held by a stalled sink.
// Synchronous active-low reset; no clearing pass, ready right after reset.
module ubx_frame_receiver_top
    import ubx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_item_kind,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_byte_index,
    output logic [7:0]  m_frame_class,
    output logic [7:0]  m_frame_id,
    output logic [15:0] m_frame_length,
    output logic [1:0]  m_frame_status,
    output logic        m_last_of_frame,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);

    logic    step;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign step = s_valid && s_ready;

    ubx_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .rx_byte     (s_rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_valid   (res_valid),
        .res         (res)
    );

    ubx_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step && res_valid),
        .push_data (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_item_kind     = out_data.item_kind;
    assign m_payload_byte  = out_data.payload_byte;
    assign m_byte_index    = out_data.byte_index;
    assign m_frame_class   = out_data.frame_class;
    assign m_frame_id      = out_data.frame_id;
    assign m_frame_length  = out_data.frame_length;
    assign m_frame_status  = out_data.frame_status;
    assign m_last_of_frame = out_data.last_of_frame;

endmodule

/* dv/tb.sv */
// Testbench for the UBX frame receiver: byte stream stimulus, frame tracker and result checks
`timescale 1ns / 1ps

module tb
    import ubx_pkg::*;
;

    typedef enum logic [3:0] {
        ST_HUNT, ST_SYNC2, ST_CLASS, ST_ID, ST_LEN_LO, ST_LEN_HI, ST_PAYLOAD, ST_CK_A, ST_CK_B
    } parse_state_t;

    class ubx_frame_tracker;
        logic [8:0]   max_len;
        parse_state_t state;
        logic [7:0]   sum_a;
        logic [7:0]   sum_b;
        logic [7:0]   frm_class;
        logic [7:0]   frm_id;
        logic [15:0]  frm_len;
        logic [8:0]   count;
        logic [7:0]   rx_ck_a;
        result_t      expected_items[$];
        int           mismatches;

        function new();
            max_len    = PAYLOAD_CEILING;
            state      = ST_HUNT;
            sum_a      = '0;
            sum_b      = '0;
            frm_class  = '0;
            frm_id     = '0;
            frm_len    = '0;
            count      = '0;
            rx_ck_a    = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_items.size();
        endfunction

        function void fold(logic [7:0] b);
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
        endfunction

        function void push(logic kind, logic [7:0] value, logic [7:0] idx, logic [1:0] status);
            result_t r;
            r.item_kind     = kind;
            r.payload_byte  = value;
            r.byte_index    = idx;
            r.frame_class   = frm_class;
            r.frame_id      = frm_id;
            r.frame_length  = frm_len;
            r.frame_status  = status;
            r.last_of_frame = kind;
            expected_items.push_back(r);
        endfunction

        function void note_byte(logic [7:0] b);
            logic [8:0] eff;
            eff = (max_len > PAYLOAD_CEILING) ? PAYLOAD_CEILING : max_len;
            case (state)
                ST_SYNC2: begin
                    if (b == SYNC_SECOND) begin
                        sum_a = '0;
                        sum_b = '0;
                        state = ST_CLASS;
                    end else begin
                        state = ST_HUNT;
                    end
                end
                ST_CLASS: begin
                    frm_class = b;
                    fold(b);
                    state = ST_ID;
                end
                ST_ID: begin
                    frm_id = b;
                    fold(b);
                    state = ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    frm_len = {8'h00, b};
                    fold(b);
                    state = ST_LEN_HI;
                end
                ST_LEN_HI: begin
                    frm_len[15:8] = b;
                    fold(b);
                    count = '0;
                    if (frm_len > {7'd0, eff}) begin
                        push(KIND_END, 8'h00, 8'h00, STATUS_LENGTH);
                        state = ST_HUNT;
                    end else if (frm_len == 16'd0) begin
                        state = ST_CK_A;
                    end else begin
                        state = ST_PAYLOAD;
                    end
                end
                ST_PAYLOAD: begin
                    fold(b);
                    push(KIND_PAYLOAD, b, count[7:0], STATUS_OK);
                    count = count + 9'd1;
                    if ({7'd0, count} >= frm_len) state = ST_CK_A;
                end
                ST_CK_A: begin
                    rx_ck_a = b;
                    state = ST_CK_B;
                end
                ST_CK_B: begin
                    if (rx_ck_a == sum_a && b == sum_b) push(KIND_END, 8'h00, 8'h00, STATUS_OK);
                    else push(KIND_END, 8'h00, 8'h00, STATUS_CHECKSUM);
                    state = ST_HUNT;
                end
                default: begin
                    if (b == SYNC_FIRST) state = ST_SYNC2;
                    else state = ST_HUNT;
                end
            endcase
        endfunction

        function string fmt(result_t r);
            return $sformatf("kind=%0d byte=%02h idx=%0d cls=%02h id=%02h len=%0d st=%0d last=%0d",
                             r.item_kind, r.payload_byte, r.byte_index, r.frame_class,
                             r.frame_id, r.frame_length, r.frame_status, r.last_of_frame);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_items.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: %s", fmt(got));
                return;
            end
            want = expected_items.pop_front();
            if (got.item_kind !== want.item_kind || got.payload_byte !== want.payload_byte ||
                got.byte_index !== want.byte_index || got.frame_class !== want.frame_class ||
                got.frame_id !== want.frame_id || got.frame_length !== want.frame_length ||
                got.frame_status !== want.frame_status ||
                got.last_of_frame !== want.last_of_frame) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %s", fmt(want));
                    $display("  actual   %s", fmt(got));
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_item_kind;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_byte_index;
    logic [7:0]  m_frame_class;
    logic [7:0]  m_frame_id;
    logic [15:0] m_frame_length;
    logic [1:0]  m_frame_status;
    logic        m_last_of_frame;
    logic        cfg_wr_en = 1'b0;
    logic [8:0]  cfg_wr_data = 9'd0;

    ubx_frame_tracker tracker = new();
    logic [7:0]       stream[$];
    int               eff_limit = 256;
    int               sender_idle_pct = 0;
    int               recv_stall_pct = 0;

    ubx_frame_receiver_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item_kind     (m_item_kind),
        .m_payload_byte  (m_payload_byte),
        .m_byte_index    (m_byte_index),
        .m_frame_class   (m_frame_class),
        .m_frame_id      (m_frame_id),
        .m_frame_length  (m_frame_length),
        .m_frame_status  (m_frame_status),
        .m_last_of_frame (m_last_of_frame),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_result(result_t'({m_item_kind, m_payload_byte, m_byte_index,
                                            m_frame_class, m_frame_id, m_frame_length,
                                            m_frame_status, m_last_of_frame}));
        end
    end

    task automatic write_limit(logic [8:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.max_len = value;
        eff_limit = (value > PAYLOAD_CEILING) ? 256 : int'(value);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1: begin
                sender_idle_pct = 58;
                recv_stall_pct  = 0;
            end
            2: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 58;
            end
            3: begin
                sender_idle_pct = 31;
                recv_stall_pct  = 31;
            end
            default: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
        endcase
    endtask

    // over-limit frames carry the header only
    function automatic void queue_frame(logic [7:0] cls, logic [7:0] id, int len, int corrupt);
        logic [7:0]  body[$];
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [7:0]  pb;
        logic [15:0] l16;
        l16  = len[15:0];
        body = {cls, id, l16[7:0], l16[15:8]};
        if (len <= eff_limit) begin
            for (int i = 0; i < len; i++) begin
                pb = 8'($urandom_range(255));
                if ($urandom_range(7) == 0) pb = SYNC_FIRST;
                body.push_back(pb);
            end
        end
        ck_a = '0;
        ck_b = '0;
        foreach (body[i]) begin
            ck_a = ck_a + body[i];
            ck_b = ck_b + ck_a;
        end
        if (corrupt == 1) ck_a = ck_a ^ (8'd1 << $urandom_range(7));
        if (corrupt == 2) ck_b = ck_b ^ (8'd1 << $urandom_range(7));
        stream.push_back(SYNC_FIRST);
        stream.push_back(SYNC_SECOND);
        foreach (body[i]) stream.push_back(body[i]);
        if (len <= eff_limit) begin
            stream.push_back(ck_a);
            stream.push_back(ck_b);
        end
    endfunction

    function automatic void build_random(int n);
        int         r;
        int         len;
        int         corrupt;
        logic [7:0] pb;
        while (stream.size() < n) begin
            r = $urandom_range(99);
            if (r < 70) begin
                r = $urandom_range(99);
                if (r < 80) len = $urandom_range((eff_limit < 12) ? eff_limit : 12, 0);
                else if (r < 93) len = $urandom_range((eff_limit < 40) ? eff_limit : 40, 0);
                else if (r < 97) len = eff_limit + $urandom_range(4, 1);
                else len = $urandom_range(65535, eff_limit + 1);
                r = $urandom_range(99);
                corrupt = (r < 10) ? 1 : (r < 20) ? 2 : 0;
                queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, corrupt);
            end else if (r < 80) begin
                stream.push_back(SYNC_FIRST);
                if ($urandom_range(1)) begin
                    stream.push_back(SYNC_FIRST);
                    stream.push_back(SYNC_SECOND);
                end else begin
                    pb = 8'($urandom_range(255));
                    if (pb == SYNC_SECOND) pb = 8'h00;
                    stream.push_back(pb);
                end
            end else begin
                repeat ($urandom_range(6, 1)) stream.push_back(8'($urandom_range(255)));
            end
        end
    endfunction

    task automatic send_byte(logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_byte(b);
    endtask

    task automatic drive_stream(int pause_at);
        for (int i = 0; i < stream.size(); i++) begin
            if (i == pause_at) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (tracker.pending() != 0) @(negedge aclk);
            end
            send_byte(stream[i]);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
        stream.delete();
    endtask

    task automatic settle();
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        int cfg_plan [7];
        cfg_plan    = '{0, 511, 5, 1, 300, 20, 0};
        cfg_plan[6] = $urandom_range(511);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_limit(9'd256);
        set_idling(0);
        queue_frame(8'h00, 8'hFF, 0, 0);
        queue_frame(8'hFF, 8'h00, 0, 2);
        stream.push_back(SYNC_FIRST);
        stream.push_back(SYNC_FIRST);
        stream.push_back(SYNC_SECOND);
        stream.push_back(8'h00);
        stream.push_back(SYNC_FIRST);
        stream.push_back(8'h00);
        queue_frame(8'h05, 8'h01, 257, 0);
        drive_stream(stream.size() / 2);
        settle();

        for (int p = 0; p < 7; p++) begin
            write_limit(cfg_plan[p][8:0]);
            set_idling((p + 1) % 4);
            if (p == 1) begin
                queue_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 256, 0);
            end
            build_random(stream.size() + 50);
            drive_stream($urandom_range(stream.size() - 1));
            settle();
        end

        repeat (8) @(negedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
